@@ rtl/core/wlanfid_pkg.sv @@
package wlanfid_pkg;

  localparam int IFS   = 4;
  localparam int STAS  = 16;
  localparam int PRIOS = 8;

  localparam int IF_W    = $clog2(IFS);
  localparam int STA_W   = $clog2(STAS);
  localparam int PRIO_W  = $clog2(PRIOS);
  localparam int CELL_W  = IF_W + STA_W;
  localparam int FLOW_AW = CELL_W + PRIO_W;
  localparam int CELLS   = IFS * STAS;
  localparam int SLOTS   = CELLS * PRIOS;

  localparam logic [15:0] NO_FLOW    = 16'hFFFF;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_NOMATCH = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ABSENT  = 3'd4;

endpackage

@@ rtl/core/wlan_flow_id_table_unit.sv @@
// Flow id table: one command beat at a time, result strobed on done for one cycle.
// Add and lookup scan the STAS entries of the interface in the MAC memory; a miss or a
// full table ends the command there. Station-role add and lookup skip the scan, a bad
// command goes straight to the result, and delete makes one pass over all STAS*PRIOS
// flow slots of the interface. A new beat can be taken while done is high. The receiver
// cannot stall. Synchronous active-high reset, then a flow memory clear, busy high.
module wlan_flow_id_table_unit import wlanfid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [2:0]  if_index,
  input  logic        station_role,
  input  logic [31:0] out_if,
  input  logic [15:0] flow_number,
  input  logic [2:0]  slot_prio,
  input  logic [2:0]  user_prio,
  input  logic [15:0] ether_type,
  input  logic [47:0] dest_mac,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] found_flow,
  output logic [31:0] if_out_readback
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_ADD, S_LREAD, S_LWAIT, S_DEL, S_DONE
  } state_t;

  state_t state;

  // config and small per-interface state
  logic [23:0]      prio_map;
  logic [CELLS-1:0] station_valid;
  logic [IFS-1:0]   iface_is_station;
  logic [31:0]      iface_out [IFS];

  // memories
  logic [47:0] mac_mem  [CELLS];
  logic [15:0] flow_mem [SLOTS];
  logic [47:0] mac_rd;
  logic [15:0] flow_rd;

  // latched command
  logic [1:0]        op_q;
  logic [IF_W-1:0]   ifx;
  logic              bad;
  logic [31:0]       oif;
  logic [15:0]       flow;
  logic [PRIO_W-1:0] fprio;
  logic [PRIO_W-1:0] prio;
  logic [47:0]       mac;

  // scan and delete sequencing
  logic [STA_W:0]          cnt;
  logic                    pend;
  logic [STA_W-1:0]        pend_s;
  logic                    hit;
  logic [STA_W-1:0]        hit_s;
  logic                    free_found;
  logic [STA_W-1:0]        free_s;
  logic [STA_W-1:0]        sel_s;
  logic [STA_W+PRIO_W:0]   del_cnt;
  logic                    del_pend;
  logic [STA_W+PRIO_W-1:0] del_addr;
  logic                    removed;
  logic                    all_empty;
  logic [FLOW_AW-1:0]      clr_cnt;
  logic [2:0]              res_status;
  logic [15:0]             res_found;

  // memory port controls
  logic [CELL_W-1:0]  mac_raddr;
  logic               mac_we;
  logic [CELL_W-1:0]  mac_waddr;
  logic [FLOW_AW-1:0] flow_raddr;
  logic               flow_we;
  logic [FLOW_AW-1:0] flow_waddr;
  logic [15:0]        flow_wdata;

  logic [CELL_W-1:0] pend_cell;
  logic [CELL_W-1:0] sel_cell;
  logic [CELL_W-1:0] del_cell;
  logic              del_match;
  logic              del_empty;
  logic              del_first;
  logic              del_last;

  assign busy      = (state != S_IDLE);
  assign pend_cell = {ifx, pend_s};
  assign sel_cell  = {ifx, sel_s};
  assign del_cell  = {ifx, del_addr[STA_W+PRIO_W-1:PRIO_W]};
  assign del_match = (flow != NO_FLOW) && (flow_rd == flow);
  assign del_empty = del_match || (flow_rd == NO_FLOW);
  assign del_first = (del_addr[PRIO_W-1:0] == '0);
  assign del_last  = (del_addr[PRIO_W-1:0] == PRIO_W'(PRIOS - 1));

  // read addresses
  always_comb begin
    mac_raddr  = {ifx, cnt[STA_W-1:0]};
    flow_raddr = {ifx, del_cnt[STA_W+PRIO_W-1:0]};
    if (state == S_LREAD) begin
      flow_raddr = {sel_cell, prio};
    end
  end

  // write ports
  always_comb begin
    mac_we     = 1'b0;
    mac_waddr  = sel_cell;
    flow_we    = 1'b0;
    flow_waddr = {sel_cell, fprio};
    flow_wdata = flow;
    case (state)
      S_CLEAR: begin
        flow_we    = 1'b1;
        flow_waddr = clr_cnt;
        flow_wdata = NO_FLOW;
      end
      S_ADD: begin
        mac_we  = !station_valid[sel_cell];
        flow_we = 1'b1;
      end
      S_DEL: begin
        flow_we    = del_pend && del_match;
        flow_waddr = {del_cell, del_addr[PRIO_W-1:0]};
        flow_wdata = NO_FLOW;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mac_we) begin
      mac_mem[mac_waddr] <= mac;
    end
    mac_rd <= mac_mem[mac_raddr];
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[flow_waddr] <= flow_wdata;
    end
    flow_rd <= flow_mem[flow_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_cnt          <= '0;
      prio_map         <= '0;
      station_valid    <= '0;
      iface_is_station <= '0;
      for (int i = 0; i < IFS; i++) begin
        iface_out[i] <= '1;
      end
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        prio_map <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == FLOW_AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            op_q       <= opcode;
            ifx        <= if_index[IF_W-1:0];
            oif        <= out_if;
            flow       <= flow_number;
            fprio      <= slot_prio;
            prio       <= prio_map[3*user_prio +: 3];
            mac        <= dest_mac;
            bad        <= (32'(if_index) >= IFS);
            res_found  <= '0;
            res_status <= ST_OK;
            cnt        <= '0;
            pend       <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            sel_s      <= '0;
            del_cnt    <= '0;
            del_pend   <= 1'b0;
            removed    <= 1'b0;
            if (32'(if_index) >= IFS || !(opcode inside {OP_ADD, OP_LOOKUP, OP_DELETE})) begin
              res_status <= ST_BAD;
              state      <= S_DONE;
            end else begin
              case (opcode)
                OP_ADD: begin
                  iface_is_station[if_index[IF_W-1:0]] <= station_role;
                  state <= station_role ? S_ADD : S_SCAN;
                end
                OP_LOOKUP: begin
                  if (ether_type != ETYPE_IPV4 && ether_type != ETYPE_IPV6) begin
                    res_status <= ST_BAD;
                    state      <= S_DONE;
                  end else if (iface_is_station[if_index[IF_W-1:0]]) begin
                    state <= S_LREAD;
                  end else begin
                    state <= S_SCAN;
                  end
                end
                default: begin
                  state <= S_DEL;
                end
              endcase
            end
          end
        end

        // station scan: issue one read a cycle, compare the one before
        S_SCAN: begin
          if (!cnt[STA_W]) begin
            pend   <= 1'b1;
            pend_s <= cnt[STA_W-1:0];
            cnt    <= cnt + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (station_valid[pend_cell] && mac_rd == mac && !hit) begin
              hit   <= 1'b1;
              hit_s <= pend_s;
            end
            if (!station_valid[pend_cell] && !free_found) begin
              free_found <= 1'b1;
              free_s     <= pend_s;
            end
          end
          if (cnt[STA_W] && !pend) begin
            if (op_q == OP_ADD) begin
              if (hit) begin
                sel_s <= hit_s;
                state <= S_ADD;
              end else if (free_found) begin
                sel_s <= free_s;
                state <= S_ADD;
              end else begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end
            end else if (hit) begin
              sel_s <= hit_s;
              state <= S_LREAD;
            end else begin
              res_status <= ST_NOMATCH;
              state      <= S_DONE;
            end
          end
        end

        S_ADD: begin
          iface_out[ifx]          <= oif;
          station_valid[sel_cell] <= 1'b1;
          state                   <= S_DONE;
        end

        S_LREAD: begin
          state <= S_LWAIT;
        end

        S_LWAIT: begin
          if (flow_rd == NO_FLOW) begin
            res_status <= ST_NOMATCH;
          end else begin
            res_found <= flow_rd;
          end
          state <= S_DONE;
        end

        // delete pass over every slot of the interface
        S_DEL: begin
          if (!del_cnt[STA_W+PRIO_W]) begin
            del_pend <= 1'b1;
            del_addr <= del_cnt[STA_W+PRIO_W-1:0];
            del_cnt  <= del_cnt + 1'b1;
          end else begin
            del_pend <= 1'b0;
          end
          if (del_pend) begin
            if (del_match) begin
              removed <= 1'b1;
            end
            all_empty <= (del_first || all_empty) && del_empty;
            if (del_last && (del_first || all_empty) && del_empty) begin
              station_valid[del_cell] <= 1'b0;
            end
          end
          if (del_cnt[STA_W+PRIO_W] && !del_pend) begin
            res_status <= removed ? ST_OK : ST_ABSENT;
            state      <= S_DONE;
          end
        end

        S_DONE: begin
          done            <= 1'b1;
          status          <= res_status;
          found_flow      <= res_found;
          if_out_readback <= bad ? 32'd0 : iface_out[ifx];
          state           <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`default_nettype none

module tb;
  import wlanfid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int MAC_POOL = 20;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  ifx;
    logic        role;
    logic [31:0] oif;
    logic [15:0] flow;
    logic [2:0]  fprio;
    logic [2:0]  uprio;
    logic [15:0] etype;
    logic [47:0] mac;
  } fid_cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] found;
    logic [31:0] readback;
  } fid_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [2:0]  if_index = '0;
  logic        station_role = 1'b0;
  logic [31:0] out_if = '0;
  logic [15:0] flow_number = '0;
  logic [2:0]  slot_prio = '0;
  logic [2:0]  user_prio = '0;
  logic [15:0] ether_type = '0;
  logic [47:0] dest_mac = '0;
  logic        done;
  logic [2:0]  status;
  logic [15:0] found_flow;
  logic [31:0] if_out_readback;

  wlan_flow_id_table_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .opcode(opcode), .if_index(if_index),
    .station_role(station_role), .out_if(out_if), .flow_number(flow_number),
    .slot_prio(slot_prio), .user_prio(user_prio), .ether_type(ether_type),
    .dest_mac(dest_mac), .done(done), .status(status), .found_flow(found_flow),
    .if_out_readback(if_out_readback)
  );

  initial forever #6 clk = ~clk;

  // Shadow copy of the table
  logic [23:0] prio_map;
  logic        sta_valid [CELLS];
  logic [47:0] sta_mac   [CELLS];
  logic [15:0] flow_slot [SLOTS];
  logic        if_station[IFS];
  logic [31:0] if_out_tab[IFS];

  fid_rsp_t pending_rsp[$];
  int       errors = 0;
  longint   cycles = 0;
  logic [47:0] mac_pool[MAC_POOL];

  function automatic void clear_table();
    prio_map = '0;
    for (int i = 0; i < CELLS; i++) begin
      sta_valid[i] = 1'b0;
      sta_mac[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) flow_slot[i] = NO_FLOW;
    for (int i = 0; i < IFS; i++) begin
      if_station[i] = 1'b0;
      if_out_tab[i] = '1;
    end
  endfunction

  // Slot 0 on a station-role interface, else matching station, else first free one if allowed, else -1
  function automatic int find_station(int ifx, logic [47:0] mac, bit take_free);
    int free_s;
    int c;
    free_s = -1;
    if (if_station[ifx]) return 0;
    for (int s = 0; s < STAS; s++) begin
      c = ifx * STAS + s;
      if (sta_valid[c] && sta_mac[c] == mac) return s;
      if (!sta_valid[c] && free_s < 0) free_s = s;
    end
    return take_free ? free_s : -1;
  endfunction

  function automatic fid_rsp_t apply_cmd(fid_cmd_t cmd);
    fid_rsp_t r;
    int ifx;
    int s;
    int c;
    int empty;
    logic [2:0] p;
    logic [15:0] v;
    bit removed;
    r.status = ST_OK;
    r.found = '0;
    ifx = cmd.ifx;
    if (ifx >= IFS || cmd.op == OP_UNKNOWN) begin
      r.status = ST_BAD;
    end else if (cmd.op == OP_ADD) begin
      if_station[ifx] = cmd.role;
      s = find_station(ifx, cmd.mac, 1'b1);
      if (s < 0) begin
        r.status = ST_FULL;
      end else begin
        c = ifx * STAS + s;
        if_out_tab[ifx] = cmd.oif;
        if (!sta_valid[c]) begin
          sta_mac[c] = cmd.mac;
          sta_valid[c] = 1'b1;
        end
        flow_slot[c * PRIOS + cmd.fprio] = cmd.flow;
      end
    end else if (cmd.op == OP_LOOKUP) begin
      if (cmd.etype != ETYPE_IPV4 && cmd.etype != ETYPE_IPV6) begin
        r.status = ST_BAD;
      end else begin
        p = prio_map[3 * cmd.uprio +: 3];
        s = find_station(ifx, cmd.mac, 1'b0);
        if (s < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          v = flow_slot[(ifx * STAS + s) * PRIOS + p];
          if (v == NO_FLOW) r.status = ST_NOMATCH;
          else r.found = v;
        end
      end
    end else begin
      removed = 1'b0;
      for (int st = 0; st < STAS; st++) begin
        c = ifx * STAS + st;
        if (sta_valid[c]) begin
          empty = 0;
          for (int k = 0; k < PRIOS; k++) begin
            if (cmd.flow != NO_FLOW && flow_slot[c * PRIOS + k] == cmd.flow) begin
              flow_slot[c * PRIOS + k] = NO_FLOW;
              removed = 1'b1;
            end
            if (flow_slot[c * PRIOS + k] == NO_FLOW) empty++;
          end
          if (empty == PRIOS) begin
            sta_valid[c] = 1'b0;
            sta_mac[c] = '0;
          end
        end
      end
      if (!removed) r.status = ST_ABSENT;
    end
    r.readback = (ifx < IFS) ? if_out_tab[ifx] : '0;
    return r;
  endfunction

  // Gap length: mostly short, sometimes long
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 4);
  endfunction

  // Drive one command beat and wait until busy drops
  task automatic send_cmd(fid_cmd_t cmd, int gap);
    start        <= 1'b1;
    opcode       <= cmd.op;
    if_index     <= cmd.ifx;
    station_role <= cmd.role;
    out_if       <= cmd.oif;
    flow_number  <= cmd.flow;
    slot_prio    <= cmd.fprio;
    user_prio    <= cmd.uprio;
    ether_type   <= cmd.etype;
    dest_mac     <= cmd.mac;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(apply_cmd(cmd));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_prio_map(logic [23:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    prio_map = value;
    @(posedge clk);
  endtask

  function automatic fid_cmd_t make_cmd(logic [1:0] op, logic [2:0] ifx, logic [47:0] mac,
                                        logic [15:0] flow, logic [2:0] prio);
    fid_cmd_t c;
    c.op = op;
    c.ifx = ifx;
    c.role = 1'b0;
    c.oif = $urandom;
    c.flow = flow;
    c.fprio = prio;
    c.uprio = prio;
    c.etype = ETYPE_IPV4;
    c.mac = mac;
    return c;
  endfunction

  task automatic test_directed();
    fid_cmd_t c;
    // basic add, lookup with identity map, delete
    c = make_cmd(OP_ADD, 3'd0, 48'hFFFF_FFFF_FFFF, 16'h0000, 3'd7);
    c.oif = 32'hFFFF_FFFF;
    send_cmd(c, 0);
    c = make_cmd(OP_ADD, 3'd0, 48'h0, 16'hFFFE, 3'd0);
    c.oif = 32'h0;
    send_cmd(c, 1);
    c = make_cmd(OP_LOOKUP, 3'd0, 48'hFFFF_FFFF_FFFF, 16'h0, 3'd7);
    send_cmd(c, 0);
    c = make_cmd(OP_LOOKUP, 3'd0, 48'h0, 16'h0, 3'd0);
    c.etype = ETYPE_IPV6;
    send_cmd(c, 0);
    // unsupported ethertype, unknown opcode, interface out of range
    c.etype = 16'hFFFF;
    send_cmd(c, 0);
    c = make_cmd(OP_UNKNOWN, 3'd1, 48'h1, 16'h1, 3'd1);
    send_cmd(c, 2);
    c = make_cmd(OP_ADD, 3'd7, 48'h1, 16'h1, 3'd1);
    send_cmd(c, 0);
    c = make_cmd(OP_LOOKUP, 3'd4, 48'h1, 16'h1, 3'd1);
    send_cmd(c, 0);
    // adding the invalid id leaves the slot empty, lookup misses
    c = make_cmd(OP_ADD, 3'd2, 48'h1234_5678_9ABC, NO_FLOW, 3'd3);
    send_cmd(c, 0);
    c = make_cmd(OP_LOOKUP, 3'd2, 48'h1234_5678_9ABC, 16'h0, 3'd3);
    send_cmd(c, 0);
    // deleting the invalid id frees the empty station
    c = make_cmd(OP_DELETE, 3'd2, 48'h0, NO_FLOW, 3'd0);
    send_cmd(c, 0);
    c = make_cmd(OP_DELETE, 3'd0, 48'h0, 16'h0000, 3'd0);
    send_cmd(c, 3);
    // station role: slot 0 whatever the MAC
    c = make_cmd(OP_ADD, 3'd3, 48'hAAAA_0000_0001, 16'h00A5, 3'd2);
    c.role = 1'b1;
    send_cmd(c, 0);
    c = make_cmd(OP_LOOKUP, 3'd3, 48'h5555_0000_0002, 16'h0, 3'd2);
    send_cmd(c, 0);
    // fill interface 1 until the table is full
    for (int i = 0; i <= STAS; i++) begin
      c = make_cmd(OP_ADD, 3'd1, 48'h0200_0000_0000 + i, 16'(i + 16'h100), 3'(i));
      send_cmd(c, 0);
    end
    c = make_cmd(OP_LOOKUP, 3'd1, 48'h0200_0000_000F, 16'h0, 3'd7);
    send_cmd(c, 0);
  endtask

  function automatic fid_cmd_t random_cmd();
    fid_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c.op = (r < 45) ? OP_ADD : (r < 80) ? OP_LOOKUP : (r < 96) ? OP_DELETE : OP_UNKNOWN;
    c.ifx = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
    c.role = ($urandom_range(0, 7) == 0);
    c.oif = $urandom;
    c.flow = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
             ($urandom_range(0, 19) == 0) ? NO_FLOW : 16'($urandom_range(0, 31));
    c.fprio = 3'($urandom);
    c.uprio = 3'($urandom);
    c.etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
              ($urandom_range(0, 1) ? ETYPE_IPV4 : ETYPE_IPV6);
    c.mac = ($urandom_range(0, 15) == 0) ? {16'($urandom), 32'($urandom)} :
            mac_pool[$urandom_range(0, MAC_POOL - 1)];
    return c;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_cmd(random_cmd(), pick_gap());
  endtask

  // Compare each result beat with the oldest prediction
  fid_rsp_t exp_rsp;
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("result beat with no prediction pending");
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, status);
          errors++;
        end
        if (found_flow !== exp_rsp.found) begin
          $error("found_flow: expected %h, got %h", exp_rsp.found, found_flow);
          errors++;
        end
        if (if_out_readback !== exp_rsp.readback) begin
          $error("if_out_readback: expected %h, got %h", exp_rsp.readback, if_out_readback);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clear_table();
    for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_prio_map(24'hFAC688);
    test_directed();
    write_prio_map(24'h000000);
    test_random(150);
    write_prio_map(24'hFFFFFF);
    test_random(150);
    write_prio_map(24'($urandom));
    test_random(150);
    write_prio_map(24'hFAC688);
    test_random(150);
    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
